[design/tre_pkg.sv]
`timescale 1ns / 1ps

package tre_pkg;

  // register indexes on the configuration port
  localparam logic [2:0] REG_NARROW_HIGH  = 3'd0;
  localparam logic [2:0] REG_WIDE_HIGH    = 3'd1;
  localparam logic [2:0] REG_ZERO_LOW     = 3'd2;
  localparam logic [2:0] REG_ONE_LOW      = 3'd3;
  localparam logic [2:0] REG_FLOAT_LOW_A  = 3'd4;
  localparam logic [2:0] REG_FLOAT_LOW_B  = 3'd5;
  localparam logic [2:0] REG_SYNC_HIGH    = 3'd6;
  localparam logic [2:0] REG_SYNC_LOW     = 3'd7;

  localparam int REG_ADDR_W = 3;
  localparam int TICK_W     = 16;
  localparam int CODE_W     = 24;
  localparam int CODE_TRITS = CODE_W / 2;

  // reset values of the duration registers
  localparam logic [TICK_W-1:0] RST_NARROW_HIGH = 16'd250;
  localparam logic [TICK_W-1:0] RST_WIDE_HIGH   = 16'd810;
  localparam logic [TICK_W-1:0] RST_ZERO_LOW    = 16'd690;
  localparam logic [TICK_W-1:0] RST_ONE_LOW     = 16'd210;
  localparam logic [TICK_W-1:0] RST_FLOAT_LOW_A = 16'd700;
  localparam logic [TICK_W-1:0] RST_FLOAT_LOW_B = 16'd200;
  localparam logic [TICK_W-1:0] RST_SYNC_HIGH   = 16'd250;
  localparam logic [TICK_W-1:0] RST_SYNC_LOW    = 16'd7000;

  // trit codes, both upper codes mean float
  localparam logic [1:0] TRIT_ZERO = 2'd0;
  localparam logic [1:0] TRIT_ONE  = 2'd1;

  // pulse phases within a trit
  localparam logic [1:0] PH_HIGH_A = 2'd0;
  localparam logic [1:0] PH_LOW_A  = 2'd1;
  localparam logic [1:0] PH_HIGH_B = 2'd2;
  localparam logic [1:0] PH_LOW_B  = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] narrow_high;
    logic [TICK_W-1:0] wide_high;
    logic [TICK_W-1:0] zero_low;
    logic [TICK_W-1:0] one_low;
    logic [TICK_W-1:0] float_low_a;
    logic [TICK_W-1:0] float_low_b;
    logic [TICK_W-1:0] sync_high;
    logic [TICK_W-1:0] sync_low;
  } dur_cfg_t;

endpackage

[design/tre_cfg_regs.sv]
`timescale 1ns / 1ps

module tre_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [tre_pkg::REG_ADDR_W-1:0]   cfg_addr,
  input  logic [tre_pkg::TICK_W-1:0]       cfg_wdata,
  output tre_pkg::dur_cfg_t                dur
);

  // duration registers, one write per cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      dur.narrow_high <= tre_pkg::RST_NARROW_HIGH;
      dur.wide_high   <= tre_pkg::RST_WIDE_HIGH;
      dur.zero_low    <= tre_pkg::RST_ZERO_LOW;
      dur.one_low     <= tre_pkg::RST_ONE_LOW;
      dur.float_low_a <= tre_pkg::RST_FLOAT_LOW_A;
      dur.float_low_b <= tre_pkg::RST_FLOAT_LOW_B;
      dur.sync_high   <= tre_pkg::RST_SYNC_HIGH;
      dur.sync_low    <= tre_pkg::RST_SYNC_LOW;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tre_pkg::REG_NARROW_HIGH: dur.narrow_high <= cfg_wdata;
        tre_pkg::REG_WIDE_HIGH:   dur.wide_high   <= cfg_wdata;
        tre_pkg::REG_ZERO_LOW:    dur.zero_low    <= cfg_wdata;
        tre_pkg::REG_ONE_LOW:     dur.one_low     <= cfg_wdata;
        tre_pkg::REG_FLOAT_LOW_A: dur.float_low_a <= cfg_wdata;
        tre_pkg::REG_FLOAT_LOW_B: dur.float_low_b <= cfg_wdata;
        tre_pkg::REG_SYNC_HIGH:   dur.sync_high   <= cfg_wdata;
        tre_pkg::REG_SYNC_LOW:    dur.sync_low    <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

[design/tristate_rf_pulse_encoder.sv]
`timescale 1ns / 1ps
// channel   | signals                         | contents
// ----------+---------------------------------+-------------------------------------------
// s_axis    | s_tvalid s_tready s_tdata s_tuser | tuser: cmd; tdata: code_word
// m_axis    | m_tvalid m_tready m_tdata m_tlast | tdata: pin_level, busy_res, start_rejected
//           |                                 | tlast: frame_done
// cfg       | cfg_we cfg_addr cfg_wdata       | duration registers, write only
//
// one request per clock unless the output stalls; results pass through the input and
// result registers. duration count, segment lookup and trit select are combinational.
// rst is synchronous, clears the frame state and loads the default durations.
// a stalled result holds in the output register; the input register takes one
// more request and then holds it, so the input stalls as long as the output does.

module tristate_rf_pulse_encoder #(
  parameter int SYMBOL_COUNT = 12
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_tvalid,
  output logic                           s_tready,
  input  logic [23:0]                    s_tdata,  // [23:0] code_word
  input  logic                           s_tuser,  // [0] cmd
  output logic                           m_tvalid,
  input  logic                           m_tready,
  output logic [7:0]                     m_tdata,  // [0] pin_level [1] busy_res
                                                   // [2] start_rejected [7:3] zero
  output logic                           m_tlast,  // frame_done
  input  logic                           cfg_we,
  input  logic [tre_pkg::REG_ADDR_W-1:0] cfg_addr,
  input  logic [tre_pkg::TICK_W-1:0]     cfg_wdata
);

  localparam int IDX_W = $clog2(SYMBOL_COUNT + 1);
  localparam logic [IDX_W-1:0] SYNC_IDX = IDX_W'(SYMBOL_COUNT);

  tre_pkg::dur_cfg_t dur;

  tre_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .dur       (dur)
  );

  // duration of one segment, zero counts as one tick
  function automatic logic [tre_pkg::TICK_W-1:0] seg_ticks(
    input tre_pkg::dur_cfg_t d,
    input logic [1:0]        trit,
    input logic [1:0]        phase,
    input logic              is_sync
  );
    logic [tre_pkg::TICK_W-1:0] t;
    if (is_sync) begin
      t = (phase == tre_pkg::PH_HIGH_A) ? d.sync_high : d.sync_low;
    end else if (trit == tre_pkg::TRIT_ZERO) begin
      t = phase[0] ? d.zero_low : d.narrow_high;
    end else if (trit == tre_pkg::TRIT_ONE) begin
      t = phase[0] ? d.one_low : d.wide_high;
    end else begin
      case (phase)
        tre_pkg::PH_HIGH_A: t = d.narrow_high;
        tre_pkg::PH_LOW_A:  t = d.float_low_a;
        tre_pkg::PH_HIGH_B: t = d.wide_high;
        default:            t = d.float_low_b;
      endcase
    end
    if (t == '0) t = tre_pkg::TICK_W'(1);
    return t;
  endfunction

  // trit select, trits past the code word read as zero
  function automatic logic [1:0] trit_at(
    input logic [tre_pkg::CODE_W-1:0] code,
    input logic [IDX_W-1:0]           idx
  );
    logic [1:0] r;
    r = tre_pkg::TRIT_ZERO;
    for (int k = 0; k < tre_pkg::CODE_TRITS; k++) begin
      if (int'(idx) == k) r = code[2*k +: 2];
    end
    return r;
  endfunction

  // input register
  logic                        in_valid;
  logic                        in_cmd;
  logic [tre_pkg::CODE_W-1:0]  in_code;
  logic                        advance;

  assign advance  = in_valid && (!m_tvalid || m_tready);
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_cmd  <= s_tuser;
      in_code <= s_tdata;
    end
  end

  // frame state
  logic                        sending, sending_next;
  logic [IDX_W-1:0]            symbol_index, symbol_index_next;
  logic [1:0]                  pulse_phase, pulse_phase_next;
  logic [tre_pkg::TICK_W-1:0]  ticks_left, ticks_left_next;
  logic [tre_pkg::CODE_W-1:0]  latched_code, latched_code_next;
  logic                        pin, done, rej;

  logic                        in_sync;
  logic [IDX_W-1:0]            adv_idx;
  logic [1:0]                  adv_phase;
  logic                        adv_sync;
  logic [tre_pkg::TICK_W-1:0]  adv_ticks;
  logic [tre_pkg::TICK_W-1:0]  start_ticks;

  // next segment position once the current one runs out
  always_comb begin
    in_sync = (symbol_index >= SYNC_IDX);
    if (in_sync) begin
      adv_idx   = symbol_index;
      adv_phase = tre_pkg::PH_LOW_A;
    end else if (pulse_phase == tre_pkg::PH_LOW_B) begin
      adv_idx   = symbol_index + IDX_W'(1);
      adv_phase = tre_pkg::PH_HIGH_A;
    end else begin
      adv_idx   = symbol_index;
      adv_phase = pulse_phase + 2'd1;
    end
    adv_sync    = (adv_idx >= SYNC_IDX);
    adv_ticks   = seg_ticks(dur, trit_at(latched_code, adv_idx), adv_phase, adv_sync);
    start_ticks = seg_ticks(dur, in_code[1:0], tre_pkg::PH_HIGH_A, 1'b0);
  end

  // per-request update
  always_comb begin
    sending_next      = sending;
    symbol_index_next = symbol_index;
    pulse_phase_next  = pulse_phase;
    ticks_left_next   = ticks_left;
    latched_code_next = latched_code;
    pin  = 1'b0;
    done = 1'b0;
    rej  = 1'b0;
    if (in_cmd) begin
      if (sending) begin
        rej = 1'b1;
        pin = !pulse_phase[0];
      end else begin
        latched_code_next = in_code;
        sending_next      = 1'b1;
        symbol_index_next = '0;
        pulse_phase_next  = tre_pkg::PH_HIGH_A;
        ticks_left_next   = start_ticks;
      end
    end else if (sending) begin
      pin = !pulse_phase[0];
      if (ticks_left > tre_pkg::TICK_W'(1)) begin
        ticks_left_next = ticks_left - tre_pkg::TICK_W'(1);
      end else if (in_sync && pulse_phase != tre_pkg::PH_HIGH_A) begin
        done              = 1'b1;
        sending_next      = 1'b0;
        symbol_index_next = '0;
        pulse_phase_next  = tre_pkg::PH_HIGH_A;
        ticks_left_next   = '0;
      end else begin
        symbol_index_next = adv_idx;
        pulse_phase_next  = adv_phase;
        ticks_left_next   = adv_ticks;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sending      <= 1'b0;
      symbol_index <= '0;
      pulse_phase  <= tre_pkg::PH_HIGH_A;
      ticks_left   <= '0;
    end else if (advance) begin
      sending      <= sending_next;
      symbol_index <= symbol_index_next;
      pulse_phase  <= pulse_phase_next;
      ticks_left   <= ticks_left_next;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) latched_code <= latched_code_next;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      m_tvalid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      m_tdata <= {5'b0, rej, sending_next, pin};
      m_tlast <= done;
    end
  end

endmodule

[design/tre_checker.sv]
`timescale 1ns / 1ps

module tre_checker (
  input logic       clk,
  input logic       rst,
  input logic       m_tvalid,
  input logic       m_tready,
  input logic [7:0] m_tdata,
  input logic       m_tlast
);

  // end of frame leaves the encoder idle
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[1])
    else $error("frame end reported while still busy");

  // a rejected start only happens mid-frame
  a_rej_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2] |-> m_tdata[1] && !m_tlast)
    else $error("start rejected while idle");

  // the pin is low whenever idle
  a_pin_busy: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[0] && !m_tlast |-> m_tdata[1])
    else $error("pin high while idle");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind tristate_rf_pulse_encoder tre_checker u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
